@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker of the relay chase sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define RCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("relay chase sequencer check failed");

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define RCS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("relay chase sequencer check failed");

`endif

@@ rtl/rcs_pkg.sv @@
// Types and constants shared by the relay chase sequencer modules.
package rcs_pkg;

    // Number of relays chased and encoder counts per detent.
    localparam int RELAY_COUNT   = 6;
    localparam int DETENT_COUNTS = 4;

    // Width of the relay_on field and of the step counter (0 .. RELAY_COUNT).
    localparam int OUT_RELAYS = 6;
    localparam int STEP_W     = $clog2(RELAY_COUNT + 1);

    // Configuration register indexes.
    localparam logic [1:0] REG_START_PERIOD     = 2'd0;
    localparam logic [1:0] REG_PERIOD_INCREMENT = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE_MS      = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] START_PERIOD_RESET     = 16'd1000;
    localparam logic [9:0]  PERIOD_INCREMENT_RESET = 10'd20;
    localparam logic [15:0] DEBOUNCE_MS_RESET      = 16'd500;

    // Largest period the encoder can dial in.
    localparam logic [15:0] PERIOD_MAX = 16'hFFFF;

    // One input item: a control-loop pass.
    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [31:0] encoder_position;
        logic               switch_changed;
    } sample_t;

    // One result item.
    typedef struct packed {
        logic [OUT_RELAYS-1:0] relay_on;
        logic [15:0]           period_ms;
        logic                  edit_target;
        logic                  program_on;
        logic                  is_running;
    } result_t;

    // Configuration values used by the update logic.
    typedef struct packed {
        logic [9:0]  period_increment;
        logic [15:0] debounce_ms;
    } cfg_t;

    // Sequencer state carried from pass to pass.
    typedef struct packed {
        logic [15:0]       period;
        logic [31:0]       last_step_time;
        logic [STEP_W-1:0] relay_step;
        logic              run_flag;
        logic              program_flag;
        logic              edit_select;
        logic [31:0]       last_press_time;
        logic [31:0]       reference_count;
    } state_t;

endpackage

@@ rtl/rcs_input_stage.sv @@
// Input register of the relay chase sequencer: holds one item until it is processed.
module rcs_input_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  rcs_pkg::sample_t sample,
    input  logic             advance,
    output logic             held_valid,
    output rcs_pkg::sample_t held
);
    import rcs_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    sample_t item_reg;
    logic    take;

    // The register is free when empty or when its item moves on this cycle.
    assign sample_stall = valid_reg && !advance;
    assign take         = sample_valid && !sample_stall;
    assign valid_next   = take || (valid_reg && !advance);

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Item payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= sample;
        end
    end

    assign held_valid = valid_reg;
    assign held       = item_reg;

endmodule

@@ rtl/rcs_update.sv @@
// Next-state and result logic for one pass of the relay chase sequencer.
module rcs_update (
    input  rcs_pkg::sample_t sample,
    input  rcs_pkg::state_t  state,
    input  rcs_pkg::cfg_t    cfg,
    output rcs_pkg::state_t  state_next,
    output rcs_pkg::result_t result
);
    import rcs_pkg::*;

    localparam logic [31:0] DETENT_UP   = 32'(DETENT_COUNTS);
    localparam logic [31:0] DETENT_DOWN = 32'(0) - 32'(DETENT_COUNTS);

    logic [31:0] press_elapsed;
    logic        press_ok;
    logic        edit_new;
    logic [31:0] diff;
    logic        move_up;
    logic        move_down;
    logic        move;
    logic [16:0] period_sum;
    logic [15:0] inc_ext;
    logic [15:0] period_new;
    logic        program_new;
    logic        run_set;
    logic [31:0] step_elapsed;
    logic        step_due;

    // Debounced button edge toggles the edit target.
    assign press_elapsed = sample.now_ms - state.last_press_time;
    assign press_ok      = sample.switch_changed && (press_elapsed > 32'(cfg.debounce_ms));
    assign edit_new      = state.edit_select ^ press_ok;

    // Encoder: only a move of exactly one detent either way counts.
    assign diff      = unsigned'(sample.encoder_position) - state.reference_count;
    assign move_up   = (diff == DETENT_UP);
    assign move_down = (diff == DETENT_DOWN);
    assign move      = move_up || move_down;

    // Period adjustment with saturation at both ends.
    assign inc_ext    = 16'(cfg.period_increment);
    assign period_sum = {1'b0, state.period} + {1'b0, inc_ext};

    always_comb
    begin
        period_new = state.period;
        if (move && !edit_new)
        begin
            if (move_up)
            begin
                period_new = period_sum[16] ? PERIOD_MAX : period_sum[15:0];
            end
            else
            begin
                period_new = (inc_ext > state.period) ? 16'd0 : (state.period - inc_ext);
            end
        end
    end

    assign program_new = state.program_flag ^ (move && edit_new);
    assign run_set     = state.run_flag || program_new;

    // Step timing on the updated period.
    assign step_elapsed = sample.now_ms - state.last_step_time;
    assign step_due     = run_set && (step_elapsed >= 32'(period_new));

    always_comb
    begin
        state_next                 = state;
        state_next.edit_select     = edit_new;
        state_next.last_press_time = press_ok ? sample.now_ms : state.last_press_time;
        state_next.reference_count = move ? unsigned'(sample.encoder_position)
                                          : state.reference_count;
        state_next.period          = period_new;
        state_next.program_flag    = program_new;
        state_next.run_flag        = run_set;
        if (step_due)
        begin
            state_next.last_step_time = sample.now_ms;
            if (state.relay_step == STEP_W'(RELAY_COUNT))
            begin
                // Blank step: the chase ends here unless program mode holds it.
                state_next.relay_step = '0;
                state_next.run_flag   = program_new;
            end
            else
            begin
                state_next.relay_step = state.relay_step + STEP_W'(1);
            end
        end
    end

    // Result fields from the updated state; relays past the field are dropped.
    always_comb
    begin
        result.relay_on = '0;
        for (int k = 0; k < OUT_RELAYS; k++)
        begin
            if (k < RELAY_COUNT)
            begin
                result.relay_on[k] = (state_next.relay_step == STEP_W'(k + 1));
            end
        end
        result.period_ms   = state_next.period;
        result.edit_target = state_next.edit_select;
        result.program_on  = state_next.program_flag;
        result.is_running  = state_next.run_flag;
    end

endmodule

@@ rtl/relay_chase_sequencer.sv @@
// Top level of the relay chase sequencer: state, configuration and result registers.
//
// Usage: each sample item is one control-loop pass (timestamp, encoder count,
// button-change flag) and produces exactly one result item (relay mask,
// period, edit target, program mode, running flag).
// Both channels use valid and stall; an item moves on a rising edge with
// valid high and stall low. The configuration port writes one register at
// each edge with cfg_write high; index 0 also reloads the period at once.
// An accepted item waits in the input register until the result register can
// take it; its result is then registered and shown on the result port.
// Throughput: one item per cycle while the receiver does not stall; each pass
// is a single step of the update logic between the input and result registers.
// Reset clears the chase state, loads the period with 1000 ms and restores
// the register defaults; no items are held.
// When the receiver stalls, the result register holds its item and the input
// register keeps one more item; after that sample_stall is raised.
module relay_chase_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  rcs_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_stall,
    output rcs_pkg::result_t result,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import rcs_pkg::*;

    logic        held_valid;
    sample_t     held;
    logic        advance;
    state_t      state_reg;
    state_t      state_next;
    state_t      state_upd;
    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    result_t     result_reg;
    result_t     result_upd;
    logic        result_valid_reg;
    logic        result_valid_next;

    // Input register.
    rcs_input_stage u_input (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .advance      (advance),
        .held_valid   (held_valid),
        .held         (held)
    );

    // One pass of the sequencer.
    rcs_update u_update (
        .sample     (held),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_upd),
        .result     (result_upd)
    );

    // A held item is processed when the result register can take its result.
    assign advance = held_valid && (!result_valid_reg || !result_stall);
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PERIOD_INCREMENT: cfg_next.period_increment = cfg_data[9:0];
                REG_DEBOUNCE_MS:      cfg_next.debounce_ms      = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // State update; a start period write reloads the period.
    always_comb
    begin
        state_next = advance ? state_upd : state_reg;
        if (cfg_write && (cfg_index == REG_START_PERIOD))
        begin
            state_next.period = cfg_data;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_increment  <= PERIOD_INCREMENT_RESET;
            cfg_reg.debounce_ms       <= DEBOUNCE_MS_RESET;
            state_reg.period          <= START_PERIOD_RESET;
            state_reg.last_step_time  <= '0;
            state_reg.relay_step      <= '0;
            state_reg.run_flag        <= 1'b0;
            state_reg.program_flag    <= 1'b0;
            state_reg.edit_select     <= 1'b0;
            state_reg.last_press_time <= '0;
            state_reg.reference_count <= '0;
            result_valid_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_upd;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/rcs_checker.sv @@
// Port-level checker for the relay chase sequencer and its bind statement.
`include "assert_macros.svh"

module rcs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_stall,
    input rcs_pkg::result_t result
);
    import rcs_pkg::*;

    // A stalled result stays offered and unchanged.
    `RCS_ASSERT_NXT(a_result_held, result_valid && result_stall, result_valid)
    `RCS_ASSERT_NXT(a_result_stable, result_valid && result_stall, $stable(result))

    // At most one relay is energized at a time.
    `RCS_ASSERT_IMP(a_one_relay, result_valid, $onehot0(result.relay_on))

    // The chase only stops on the blank step.
    `RCS_ASSERT_IMP(a_idle_blank, result_valid && !result.is_running, result.relay_on == '0)

    // Program mode keeps the chase running.
    `RCS_ASSERT_IMP(a_program_runs, result_valid && result.program_on, result.is_running)

endmodule

bind relay_chase_sequencer rcs_checker u_rcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

@@ verif/relay_chase_checker.sv @@
// Checker for the relay chase sequencer: predicts each result item and compares it.
`timescale 1ns / 100ps

module relay_chase_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    input  logic             sample_stall,
    input  rcs_pkg::sample_t sample,
    input  logic             result_valid,
    input  logic             result_stall,
    input  rcs_pkg::result_t result,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output int               mismatches,
    output int               outstanding,
    output int               compared
);

    // Encoder moves that count as exactly one detent, either way.
    localparam logic [31:0] DETENT_UP   = 32'(rcs_pkg::DETENT_COUNTS);
    localparam logic [31:0] DETENT_DOWN = 32'd0 - DETENT_UP;

    // Mirrored configuration registers.
    logic [9:0]  cfg_incr;
    logic [15:0] cfg_debounce;

    // Mirrored sequencer state.
    logic [15:0] cur_period;
    logic [31:0] step_stamp;
    int          relay_pos;
    logic        chase_running;
    logic        program_mode;
    logic        edit_prog;
    logic [31:0] press_stamp;
    logic [31:0] detent_ref;

    // Results predicted for accepted passes, oldest first.
    rcs_pkg::result_t relay_outputs_due[$];

    // One line per mismatch; printing is capped, counting is not.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 100)
            $display("relay_chase_checker: %0t ns: %s: got %0h, expected %0h",
                     $time, what, got, want);
        mismatches++;
    endtask

    // One control-loop pass: button edge, then encoder, then step timing.
    task automatic run_pass(input rcs_pkg::sample_t s, output rcs_pkg::result_t r);
        logic [31:0]                   enc_diff;
        logic [16:0]                   raised;
        logic [rcs_pkg::OUT_RELAYS-1:0] mask;

        // Debounced button edge swaps what the encoder edits.
        if (s.switch_changed && (s.now_ms - press_stamp) > {16'd0, cfg_debounce})
        begin
            edit_prog   = ~edit_prog;
            press_stamp = s.now_ms;
        end

        // Only a move of exactly one detent acts and moves the reference.
        enc_diff = s.encoder_position - detent_ref;
        if (enc_diff == DETENT_UP || enc_diff == DETENT_DOWN)
        begin
            if (!edit_prog)
            begin
                if (enc_diff == DETENT_UP)
                begin
                    raised     = {1'b0, cur_period} + {7'd0, cfg_incr};
                    cur_period = raised[16] ? rcs_pkg::PERIOD_MAX : raised[15:0];
                end
                else if ({6'd0, cfg_incr} > cur_period)
                    cur_period = 16'd0;
                else
                    cur_period = cur_period - {6'd0, cfg_incr};
            end
            else
                program_mode = ~program_mode;
            detent_ref = s.encoder_position;
        end

        // Program mode holds the chase running; it stops only at the blank step.
        if (program_mode)
            chase_running = 1'b1;
        if (chase_running && (s.now_ms - step_stamp) >= {16'd0, cur_period})
        begin
            step_stamp = s.now_ms;
            relay_pos++;
            if (relay_pos > rcs_pkg::RELAY_COUNT)
            begin
                relay_pos = 0;
                if (!program_mode)
                    chase_running = 1'b0;
            end
        end

        // Pins beyond the relay outputs are dropped.
        mask = '0;
        if (relay_pos >= 1 && relay_pos <= rcs_pkg::RELAY_COUNT &&
            relay_pos <= rcs_pkg::OUT_RELAYS)
            mask[relay_pos-1] = 1'b1;

        r.relay_on    = mask;
        r.period_ms   = cur_period;
        r.edit_target = edit_prog;
        r.program_on  = program_mode;
        r.is_running  = chase_running;
    endtask

    // Watch both channels and the configuration port at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        rcs_pkg::result_t predicted;
        rcs_pkg::result_t oldest;

        if (!rst_n)
        begin
            cfg_incr      = rcs_pkg::PERIOD_INCREMENT_RESET;
            cfg_debounce  = rcs_pkg::DEBOUNCE_MS_RESET;
            cur_period    = rcs_pkg::START_PERIOD_RESET;
            step_stamp    = '0;
            relay_pos     = 0;
            chase_running = 1'b0;
            program_mode  = 1'b0;
            edit_prog     = 1'b0;
            press_stamp   = '0;
            detent_ref    = '0;
            relay_outputs_due.delete();
            outstanding   = 0;
        end
        else
        begin
            // Register writes; the start period also reloads the period.
            if (cfg_write)
            begin
                case (cfg_index)
                    rcs_pkg::REG_START_PERIOD:     cur_period   = cfg_data;
                    rcs_pkg::REG_PERIOD_INCREMENT: cfg_incr     = cfg_data[9:0];
                    rcs_pkg::REG_DEBOUNCE_MS:      cfg_debounce = cfg_data;
                    default: ;
                endcase
            end

            // Accepted input item: predict its result.
            if (sample_valid && !sample_stall)
            begin
                run_pass(sample, predicted);
                relay_outputs_due.push_back(predicted);
            end

            // Accepted result item: compare with the oldest prediction.
            if (result_valid && !result_stall)
            begin
                if (relay_outputs_due.size() == 0)
                    report_mismatch("result item with nothing outstanding",
                                    32'(result), 32'd0);
                else
                begin
                    oldest = relay_outputs_due.pop_front();
                    compared++;
                    if (result.relay_on !== oldest.relay_on)
                        report_mismatch("relay_on", 32'(result.relay_on),
                                        32'(oldest.relay_on));
                    if (result.period_ms !== oldest.period_ms)
                        report_mismatch("period_ms", 32'(result.period_ms),
                                        32'(oldest.period_ms));
                    if (result.edit_target !== oldest.edit_target)
                        report_mismatch("edit_target", 32'(result.edit_target),
                                        32'(oldest.edit_target));
                    if (result.program_on !== oldest.program_on)
                        report_mismatch("program_on", 32'(result.program_on),
                                        32'(oldest.program_on));
                    if (result.is_running !== oldest.is_running)
                        report_mismatch("is_running", 32'(result.is_running),
                                        32'(oldest.is_running));
                end
            end
            outstanding = relay_outputs_due.size();
        end
    end

    initial
    begin
        mismatches  = 0;
        compared    = 0;
        outstanding = 0;
    end

endmodule

@@ verif/relay_chase_sequencer_tb.sv @@
// Testbench top for the relay chase sequencer: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module relay_chase_sequencer_tb;

    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 240;
    localparam int          QUIET_PHASE = 7;
    localparam int          HOLD_CYCLES = 200;
    localparam int          TIMEOUT_NS  = 12_000_000;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;
    localparam logic [31:0] DETENT_UP   = 32'(rcs_pkg::DETENT_COUNTS);
    localparam logic [31:0] DETENT_DOWN = 32'd0 - DETENT_UP;

    logic             clk;
    logic             rst_n;
    logic             sample_valid;
    logic             sample_stall;
    rcs_pkg::sample_t pass_in;
    logic             result_valid;
    logic             result_stall;
    rcs_pkg::result_t pass_out;
    logic             cfg_write;
    logic [1:0]       cfg_index;
    logic [15:0]      cfg_data;

    int mismatches;
    int pending;
    int compared;

    // Stimulus bookkeeping; quiet and hold_request are shared with the receiver.
    bit          quiet;
    bit          hold_request;
    int          passes;
    int          settings;
    int          span;
    logic [31:0] clock_ms;
    logic [31:0] enc_ref;

    relay_chase_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (pass_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (pass_out),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    relay_chase_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (pass_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (pass_out),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (pending),
        .compared     (compared)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Idle stretches: mostly short, now and then long.
    function automatic int pause_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one pass and hold it until the block takes it; returns at a falling edge.
    task automatic offer_pass(input logic [31:0] now, input logic [31:0] enc,
                              input logic sw);
        int          gap;
        logic [31:0] moved;
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pause_len();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pass_in      <= '{now_ms: now, encoder_position: enc, switch_changed: sw};
        sample_valid <= 1'b1;
        do @(posedge clk); while (sample_stall);
        // Follow the block's encoder reference so that detent moves can be aimed.
        moved = enc - enc_ref;
        if (moved == DETENT_UP || moved == DETENT_DOWN)
            enc_ref = enc;
        clock_ms = now;
        passes++;
        @(negedge clk);
    endtask

    // One register write per falling edge.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Drain the block, then load a new register setting.
    task automatic load_settings(input logic [15:0] start, input logic [15:0] incr,
                                 input logic [15:0] debounce, input bit poke_unused);
        sample_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
        write_reg(rcs_pkg::REG_START_PERIOD, start);
        write_reg(rcs_pkg::REG_PERIOD_INCREMENT, incr);
        write_reg(rcs_pkg::REG_DEBOUNCE_MS, debounce);
        if (poke_unused)
            write_reg(REG_UNUSED, 16'hBEEF);
        cfg_write <= 1'b0;
        span = start / 6 + 2;
        settings++;
    endtask

    // Receiver: random stalls, plus one long hold on request.
    initial
    begin
        int run_left;
        bit stall_now;
        run_left     = 0;
        stall_now    = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                stall_now    = 1'b0;
                run_left     = 0;
                result_stall <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if (quiet || stall_now)
                    begin
                        stall_now = 1'b0;
                        run_left  = $urandom_range(1, 12);
                    end
                    else
                    begin
                        stall_now = 1'b1;
                        run_left  = pause_len();
                    end
                end
                run_left--;
                result_stall <= stall_now && !quiet;
            end
        end
    end

    // Run limit.
    initial
    begin
        #TIMEOUT_NS;
        $display("relay_chase_sequencer_tb: FAIL");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int          roll;
        int          odd_moves[9];
        logic [31:0] now;
        logic [31:0] enc;
        logic        sw;

        odd_moves    = '{1, 2, 3, 5, 8, -1, -3, -8, 32'h8000_0000};
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        pass_in      = '0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        passes       = 0;
        settings     = 1;
        span         = 2;
        clock_ms     = '0;
        enc_ref      = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed passes under the reset settings.
        offer_pass(32'd0,        32'd0,          1'b0);  // nothing moves
        offer_pass(32'd10,       32'd4,          1'b0);  // one detent up: period rises
        offer_pass(32'd20,       32'd0,          1'b0);  // one detent down
        offer_pass(32'd30,       32'd7,          1'b0);  // odd move ignored
        offer_pass(32'd40,       32'h7FFF_FFFF,  1'b1);  // largest count; press too early
        offer_pass(32'd50,       32'h8000_0000,  1'b0);  // smallest count
        offer_pass(32'd500,      32'd0,          1'b1);  // press exactly at debounce: held off
        offer_pass(32'd501,      32'd0,          1'b1);  // press accepted: edit program mode
        offer_pass(32'd510,      32'hFFFF_FFFC,  1'b0);  // detent down across zero: program on
        offer_pass(32'd1000,     32'hFFFF_FFFC,  1'b1);  // first step on equal period
        offer_pass(32'd2000,     32'hFFFF_FFFC,  1'b0);
        offer_pass(32'd2999,     32'hFFFF_FFFC,  1'b0);  // one short of the period
        offer_pass(32'd3000,     32'hFFFF_FFFC,  1'b0);
        offer_pass(32'd4000,     32'hFFFF_FFFC,  1'b0);
        offer_pass(32'd5000,     32'hFFFF_FFFC,  1'b0);
        offer_pass(32'd6000,     32'hFFFF_FFFC,  1'b0);  // last relay
        offer_pass(32'd7000,     32'hFFFF_FFFC,  1'b0);  // blank step, still running
        offer_pass(32'd7500,     32'd0,          1'b0);  // program off
        offer_pass(32'd8000,     32'd0,          1'b0);
        offer_pass(32'hFFFF_FFFF, 32'd0,         1'b1);  // top of time; edit period again
        offer_pass(32'd998,      32'd0,          1'b0);  // across the wrap, one short
        offer_pass(32'd999,      32'd0,          1'b0);  // across the wrap, on time
        offer_pass(32'd1999,     32'd4,          1'b0);  // period up, no step
        offer_pass(32'd2019,     32'hFFFF_FFFF,  1'b0);  // odd move ignored; step

        // Random passes over several register settings.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: load_settings(rcs_pkg::START_PERIOD_RESET,
                                 16'(rcs_pkg::PERIOD_INCREMENT_RESET),
                                 rcs_pkg::DEBOUNCE_MS_RESET, 1'b0);
                1: load_settings(16'd0, 16'd1, 16'd0, 1'b0);            // zero start period
                2: load_settings(16'hFFFF, 16'd1000, 16'hFFFF, 1'b0);   // largest start period and debounce
                3: load_settings(16'd30, 16'd0, 16'd3, 1'b0);           // zero increment
                4: load_settings(16'd65500, 16'hFFFF, 16'd10, 1'b0);    // upper increment bits
                5: load_settings(16'd5, 16'd7, 16'd100, 1'b1);          // unknown index too
                6: load_settings(16'($urandom), 16'($urandom_range(1, 1000)),
                                 16'($urandom), 1'b0);
                default: load_settings(16'd40, 16'd5, 16'd20, 1'b0);
            endcase
            // Start the widest setting just below the time wrap.
            if (p == 2)
                clock_ms = 32'hFFFF_0000;
            quiet = (p == QUIET_PHASE);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (quiet && i == 40)
                    hold_request = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 4)
                begin
                    // Noise: arbitrary time and encoder count.
                    now = $urandom;
                    enc = $urandom;
                end
                else
                begin
                    now  = clock_ms + $urandom_range(0, span);
                    roll = $urandom_range(0, 99);
                    if (roll < 55)
                        enc = enc_ref;
                    else if (roll < 85)
                        enc = ($urandom_range(0, 1) != 0) ? enc_ref + DETENT_UP
                                                          : enc_ref + DETENT_DOWN;
                    else
                        enc = enc_ref + odd_moves[$urandom_range(0, 8)];
                end
                sw = ($urandom_range(0, 99) < 15);
                offer_pass(now, enc, sw);
            end
            quiet = 1'b0;
        end

        // Drain and settle.
        sample_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge clk);

        $display("Run covered %0d control passes over %0d register settings,", passes,
                 settings);
        $display("with a long receiver hold; %0d result items compared field by field.",
                 compared);
        if (mismatches == 0)
            $display("relay_chase_sequencer_tb: PASS");
        else
            $display("relay_chase_sequencer_tb: FAIL");
        $finish;
    end

endmodule
